// File: rtl/cabn_pkg.sv
// shared types and constants for the class-aware box suppression block
`timescale 1ns / 1ps

package cabn_pkg;

   // fixed field widths
   localparam int COORD_BITS   = 16;
   localparam int LABEL_BITS   = 8;
   localparam int DIFF_BITS    = COORD_BITS + 1;
   localparam int AREA_BITS    = 2 * DIFF_BITS;
   localparam int SIDE_BITS    = COORD_BITS;
   localparam int INTER_BITS   = 2 * SIDE_BITS;
   localparam int UNION_BITS   = INTER_BITS + 1;
   localparam int THRESH_BITS  = 16;
   localparam int PROD_BITS    = THRESH_BITS + UNION_BITS;
   localparam int POS_OUT_BITS = 12;
   localparam int BOX_BITS     = 4 * COORD_BITS;
   localparam int ENTRY_BITS   = LABEL_BITS + BOX_BITS + AREA_BITS;

   // threshold after reset, about 0.45 in Q0.16
   localparam logic [THRESH_BITS-1:0] THRESH_RESET = 16'd29491;

   // commands from the controller to the datapath
   typedef struct packed {
      logic load;        // capture the accepted word
      logic prep;        // compute own area, rewind the scan
      logic issue;       // read the next kept entry into the pipeline
      logic commit;      // hand the result over, store the box if kept and the list has room
   } cabn_cmd_type;

   // status from the datapath to the controller
   typedef struct packed {
      logic scan_end;    // every kept entry has been issued
      logic pipe_busy;   // compare pipeline still holds entries
      logic out_free;    // output register can take a word
   } cabn_status_type;

endpackage

// File: rtl/cabn_ctrl.sv
// controller state machine sequencing load, scan, drain and commit
`timescale 1ns / 1ps

module cabn_ctrl (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_tvalid,
   output logic                      req_tready,
   input  cabn_pkg::cabn_status_type status,
   output cabn_pkg::cabn_cmd_type    cmd
);

   typedef enum logic [4:0] {
      ST_IDLE  = 5'b00001,
      ST_PREP  = 5'b00010,
      ST_SCAN  = 5'b00100,
      ST_DRAIN = 5'b01000,
      ST_DONE  = 5'b10000
   } state_type;

   state_type state_ff;
   state_type state_in;

   // next state and commands
   always_comb begin
      state_in   = state_ff;
      cmd        = '0;
      req_tready = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd.load = 1'b1;
               state_in = ST_PREP;
            end
         end
         ST_PREP: begin
            cmd.prep = 1'b1;
            state_in = ST_SCAN;
         end
         ST_SCAN: begin
            if (status.scan_end) begin
               state_in = ST_DRAIN;
            end else begin
               cmd.issue = 1'b1;
            end
         end
         ST_DRAIN: begin
            if (!status.pipe_busy) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (status.out_free) begin
               cmd.commit = 1'b1;
               state_in   = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // state register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

// File: rtl/cabn_dpath.sv
// datapath: kept-list memory, overlap pipeline, counters and output register
`timescale 1ns / 1ps

module cabn_dpath #(
   parameter int MAX_KEPT       = 64,
   parameter int MAX_DETECTIONS = 4096,
   parameter int COORD_WIDTH    = 16
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 frame_start,
   input  logic [cabn_pkg::LABEL_BITS-1:0]      class_label,
   input  logic [cabn_pkg::COORD_BITS-1:0]      left_edge,
   input  logic [cabn_pkg::COORD_BITS-1:0]      top_edge,
   input  logic [cabn_pkg::COORD_BITS-1:0]      right_edge,
   input  logic [cabn_pkg::COORD_BITS-1:0]      bottom_edge,
   input  logic                                 csr_wen,
   input  logic [cabn_pkg::THRESH_BITS-1:0]     csr_wdata,
   input  cabn_pkg::cabn_cmd_type               cmd,
   output cabn_pkg::cabn_status_type            status,
   output logic                                 rsp_tvalid,
   input  logic                                 rsp_tready,
   output logic                                 rsp_keep,
   output logic                                 rsp_overflow,
   output logic [cabn_pkg::POS_OUT_BITS-1:0]    rsp_position
);

   localparam int CW    = (COORD_WIDTH > cabn_pkg::COORD_BITS) ? cabn_pkg::COORD_BITS
                                                               : COORD_WIDTH;
   localparam int SH    = cabn_pkg::COORD_BITS - CW;
   localparam int KW    = (MAX_KEPT > 1) ? $clog2(MAX_KEPT) : 1;
   localparam int CNT_W = $clog2(MAX_KEPT + 1);
   localparam int PW    = $clog2(MAX_DETECTIONS);
   localparam int CB    = cabn_pkg::COORD_BITS;
   localparam int DB    = cabn_pkg::DIFF_BITS;
   localparam int AB    = cabn_pkg::AREA_BITS;
   localparam int SB    = cabn_pkg::SIDE_BITS;
   localparam int IB    = cabn_pkg::INTER_BITS;
   localparam int UB    = cabn_pkg::UNION_BITS;
   localparam int PB    = cabn_pkg::PROD_BITS;
   localparam int LB    = cabn_pkg::LABEL_BITS;

   // kept-list memory, one packed entry per kept box
   logic [cabn_pkg::ENTRY_BITS-1:0] kept_mem [MAX_KEPT];

   // configuration and counters
   logic [cabn_pkg::THRESH_BITS-1:0] thresh_ff;
   logic [CNT_W-1:0]                 count_ff;
   logic [CNT_W-1:0]                 idx_ff;
   logic [PW-1:0]                    pos_ff;
   logic [PW-1:0]                    cur_pos_ff;
   logic [PW-1:0]                    pos_base;

   // current detection
   logic [LB-1:0]        label_ff;
   logic signed [CB-1:0] x1_ff, y1_ff, x2_ff, y2_ff;
   logic signed [CB-1:0] x1_in, y1_in, x2_in, y2_in;
   logic signed [DB-1:0] dx_ff, dy_ff;
   logic signed [AB-1:0] area_ff;

   // compare pipeline
   logic [cabn_pkg::ENTRY_BITS-1:0] rd_ff;
   logic                 v0_ff, v1_ff, v2_ff, v3_ff, v4_ff;
   logic [SB-1:0]        w1_ff, h1_ff;
   logic signed [AB-1:0] ka1_ff, ka2_ff;
   logic [IB-1:0]        inter2_ff, inter3_ff, inter4_ff;
   logic [UB-1:0]        uni3_ff;
   logic [PB-1:0]        prod4_ff;
   logic                 hit_ff;

   // stage one combinational terms
   logic [LB-1:0]        k_label;
   logic signed [CB-1:0] kx1, ky1, kx2, ky2;
   logic signed [AB-1:0] k_area;
   logic signed [CB-1:0] lx, ty, rx, by;
   logic signed [DB-1:0] w_full, h_full;
   logic                 overlap;
   logic signed [AB:0]   uni_full;

   // output register
   logic                          rsp_tvalid_ff;
   logic                          rsp_keep_ff;
   logic                          rsp_overflow_ff;
   logic [cabn_pkg::POS_OUT_BITS-1:0] rsp_position_ff;
   logic                          room;

   // coordinate view: low CW bits, sign extended
   always_comb begin
      x1_in = $signed(left_edge << SH) >>> SH;
      y1_in = $signed(top_edge << SH) >>> SH;
      x2_in = $signed(right_edge << SH) >>> SH;
      y2_in = $signed(bottom_edge << SH) >>> SH;
   end

   assign pos_base = frame_start ? '0 : pos_ff;
   assign room     = (count_ff < CNT_W'(MAX_KEPT));

   // capture the word and its side lengths, then its area on prep
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         label_ff   <= class_label;
         x1_ff      <= x1_in;
         y1_ff      <= y1_in;
         x2_ff      <= x2_in;
         y2_ff      <= y2_in;
         dx_ff      <= DB'(x2_in) - DB'(x1_in);
         dy_ff      <= DB'(y2_in) - DB'(y1_in);
         cur_pos_ff <= pos_base;
      end
      if (cmd.prep) begin
         area_ff <= dx_ff * dy_ff;
      end
   end

   // threshold, list fill, scan index and position counters
   always_ff @(posedge clock) begin
      if (reset) begin
         thresh_ff <= cabn_pkg::THRESH_RESET;
         count_ff  <= '0;
         pos_ff    <= '0;
         idx_ff    <= '0;
      end else begin
         if (csr_wen) begin
            thresh_ff <= csr_wdata;
         end
         if (cmd.load) begin
            if (frame_start) begin
               count_ff <= '0;
            end
            pos_ff <= (pos_base < PW'(MAX_DETECTIONS - 1)) ? pos_base + 1'b1 : pos_base;
         end
         if (cmd.prep) begin
            idx_ff <= '0;
         end else if (cmd.issue) begin
            idx_ff <= idx_ff + 1'b1;
         end
         if (cmd.commit && !hit_ff && room) begin
            count_ff <= count_ff + 1'b1;
         end
      end
   end

   // memory write on commit of a kept box while the list has room, registered read on issue
   always_ff @(posedge clock) begin
      if (cmd.commit && !hit_ff && room) begin
         kept_mem[count_ff[KW-1:0]] <= {label_ff, x1_ff, y1_ff, x2_ff, y2_ff, area_ff};
      end
      if (cmd.issue) begin
         rd_ff <= kept_mem[idx_ff[KW-1:0]];
      end
   end

   // stage one: clipped sides and label match, plus the union term for stage three
   always_comb begin
      {k_label, kx1, ky1, kx2, ky2, k_area} = rd_ff;
      lx       = (x1_ff > kx1) ? x1_ff : kx1;
      ty       = (y1_ff > ky1) ? y1_ff : ky1;
      rx       = (x2_ff < kx2) ? x2_ff : kx2;
      by       = (y2_ff < ky2) ? y2_ff : ky2;
      w_full   = DB'(rx) - DB'(lx);
      h_full   = DB'(by) - DB'(ty);
      overlap  = (rx > lx) && (by > ty);
      uni_full = (AB + 1)'(area_ff) + (AB + 1)'(ka2_ff) - (AB + 1)'(inter2_ff);
   end

   // compare pipeline registers
   always_ff @(posedge clock) begin
      w1_ff     <= w_full[SB-1:0];
      h1_ff     <= h_full[SB-1:0];
      ka1_ff    <= k_area;
      inter2_ff <= w1_ff * h1_ff;
      ka2_ff    <= ka1_ff;
      uni3_ff   <= uni_full[UB-1:0];
      inter3_ff <= inter2_ff;
      prod4_ff  <= thresh_ff * uni3_ff;
      inter4_ff <= inter3_ff;
   end

   // pipeline valid bits and suppression flag
   always_ff @(posedge clock) begin
      if (reset) begin
         v0_ff  <= 1'b0;
         v1_ff  <= 1'b0;
         v2_ff  <= 1'b0;
         v3_ff  <= 1'b0;
         v4_ff  <= 1'b0;
         hit_ff <= 1'b0;
      end else begin
         v0_ff <= cmd.issue;
         v1_ff <= v0_ff && overlap && (k_label == label_ff);
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
         v4_ff <= v3_ff;
         if (cmd.load) begin
            hit_ff <= 1'b0;
         end else if (v4_ff && ({1'b0, inter4_ff, 16'h0000} > prod4_ff)) begin
            hit_ff <= 1'b1;
         end
      end
   end

   // output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_tvalid_ff <= 1'b0;
      end else if (cmd.commit) begin
         rsp_tvalid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_tvalid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.commit) begin
         rsp_keep_ff     <= !hit_ff;
         rsp_overflow_ff <= !hit_ff && !room;
         rsp_position_ff <= cabn_pkg::POS_OUT_BITS'(cur_pos_ff);
      end
   end

   // status back to the controller
   always_comb begin
      status.scan_end  = (idx_ff == count_ff);
      status.pipe_busy = v0_ff || v1_ff || v2_ff || v3_ff || v4_ff;
      status.out_free  = !rsp_tvalid_ff || rsp_tready;
   end

   assign rsp_tvalid   = rsp_tvalid_ff;
   assign rsp_keep     = rsp_keep_ff;
   assign rsp_overflow = rsp_overflow_ff;
   assign rsp_position = rsp_position_ff;

endmodule

// File: rtl/class_aware_box_nms_core.sv
// top level of the per-class greedy box suppression block
//
//   channel  direction  tdata                                  tuser
//   req_     in         left, top, right, bottom (16b each)    frame_start, class_label
//   rsp_     out        position (12b, padded to 16b)          keep, overflow
//   csr_     in         iou threshold write, Q0.16             -
//
// the result word becomes valid after the scan of the kept list and the drain of the
// compare pipeline: one kept entry is read per cycle, and a late same-label overlap
// still has to pass the compare pipeline; the next word is taken in the cycle after the result is handed over.
// reset is synchronous: empties the kept list, zeroes the position, restores the threshold.
// a new word is accepted while the previous result still waits in the output
// register; a stalled result holds the next one in its final step.
`timescale 1ns / 1ps

module class_aware_box_nms_core #(
   parameter int MAX_KEPT       = 64,
   parameter int MAX_DETECTIONS = 4096,
   parameter int COORD_WIDTH    = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [63:0] req_tdata,   // left_edge, top_edge, right_edge, bottom_edge
   input  logic [8:0]  req_tuser,   // frame_start, class_label
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata,   // position, zero pad
   output logic [1:0]  rsp_tuser,   // keep, overflow
   input  logic        csr_wen,
   input  logic [15:0] csr_wdata
);

   cabn_pkg::cabn_cmd_type    cmd;
   cabn_pkg::cabn_status_type status;
   logic                      rsp_keep;
   logic                      rsp_overflow;
   logic [11:0]               rsp_position;

   // sequencer
   cabn_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .status     (status),
      .cmd        (cmd)
   );

   // kept list and overlap arithmetic
   cabn_dpath #(
      .MAX_KEPT       (MAX_KEPT),
      .MAX_DETECTIONS (MAX_DETECTIONS),
      .COORD_WIDTH    (COORD_WIDTH)
   ) u_dpath (
      .clock        (clock),
      .reset        (reset),
      .frame_start  (req_tuser[0]),
      .class_label  (req_tuser[8:1]),
      .left_edge    (req_tdata[15:0]),
      .top_edge     (req_tdata[31:16]),
      .right_edge   (req_tdata[47:32]),
      .bottom_edge  (req_tdata[63:48]),
      .csr_wen      (csr_wen),
      .csr_wdata    (csr_wdata),
      .cmd          (cmd),
      .status       (status),
      .rsp_tvalid   (rsp_tvalid),
      .rsp_tready   (rsp_tready),
      .rsp_keep     (rsp_keep),
      .rsp_overflow (rsp_overflow),
      .rsp_position (rsp_position)
   );

   // result word packing
   assign rsp_tdata = {4'b0000, rsp_position};
   assign rsp_tuser = {rsp_overflow, rsp_keep};

endmodule
